@@ sv/aosa_pkg.sv @@
package aosa_pkg;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_SUCC    = 2'd2,
      FUNC_RANK    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_BUSY = 2'd2
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [4:0]  slot;
   } req_type;

   typedef struct packed {
      logic [4:0]  slot_out;
      logic [5:0]  age_rank;
      status_type  status;
      logic [5:0]  in_use;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_LINK_A,
      ST_LINK_B,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic link_a;
      logic link_b;
      logic walk;
      logic finish;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     rel_ok;
      logic     walk_done;
   } sts_type;

endpackage

@@ sv/aosa_ctrl.sv @@
module aosa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  aosa_pkg::sts_type sts,
   output aosa_pkg::cmd_type cmd
);

   aosa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aosa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aosa_pkg::ST_IDLE: begin
            if (start) begin
               state_in = aosa_pkg::ST_LOOKUP;
            end
         end
         aosa_pkg::ST_LOOKUP: begin
            case (sts.func)
               aosa_pkg::FUNC_RELEASE: begin
                  state_in = sts.rel_ok ? aosa_pkg::ST_LINK_A : aosa_pkg::ST_FINISH;
               end
               aosa_pkg::FUNC_RANK: begin
                  state_in = aosa_pkg::ST_WALK;
               end
               default: begin
                  state_in = aosa_pkg::ST_FINISH;
               end
            endcase
         end
         aosa_pkg::ST_LINK_A: begin
            state_in = aosa_pkg::ST_LINK_B;
         end
         aosa_pkg::ST_LINK_B: begin
            state_in = aosa_pkg::ST_FINISH;
         end
         aosa_pkg::ST_WALK: begin
            if (sts.walk_done) begin
               state_in = aosa_pkg::ST_FINISH;
            end
         end
         aosa_pkg::ST_FINISH: begin
            state_in = aosa_pkg::ST_IDLE;
         end
         default: begin
            state_in = aosa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         aosa_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         aosa_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         aosa_pkg::ST_LINK_A: begin
            cmd.link_a = 1'b1;
         end
         aosa_pkg::ST_LINK_B: begin
            cmd.link_b = 1'b1;
         end
         aosa_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         aosa_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ sv/aosa_dpath.sv @@
module aosa_dpath #(
   parameter int SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  aosa_pkg::cmd_type cmd,
   output aosa_pkg::sts_type sts,
   input  aosa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output aosa_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(SLOTS - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS);

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] a);
      return (a == LAST_SLOT) ? '0 : IW'(a + 1'b1);
   endfunction

   function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] a);
      return (a == '0) ? LAST_SLOT : IW'(a - 1'b1);
   endfunction

   logic [IW-1:0] next_mem [SLOTS];
   logic [IW-1:0] prev_mem [SLOTS];
   logic [SLOTS-1:0] next_vld_ff, prev_vld_ff;

   aosa_pkg::func_type func_ff;
   logic [4:0]         slot_ff;

   logic [IW-1:0]    oldest_ff, oldest_in;
   logic [IW-1:0]    free_ff, free_in;
   logic [CW-1:0]    used_ff, used_in;
   logic [SLOTS-1:0] busy_ff, busy_in;

   logic [IW-1:0] next_rd_ff, next_rd_addr_ff;
   logic          next_rd_vld_ff;
   logic [IW-1:0] prev_s_rd_ff, prev_s_addr_ff;
   logic          prev_s_vld_ff;
   logic [IW-1:0] prev_o_rd_ff, prev_o_addr_ff;
   logic          prev_o_vld_ff;

   logic [IW-1:0] h_ff, hp_ff;
   logic          first_ff;
   logic [CW-1:0] rank_ff;

   logic              strobe_ff;
   aosa_pkg::rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] slot_idx, next_q, prev_s_q, prev_o_q, cur, h_c, hp_c;
   logic          in_range, rel_ok, full, walk_done, walk_step, rel_commit, alloc_commit;

   logic          next_re, prev_re, next_we, prev_we;
   logic [IW-1:0] next_ra, next_wa, next_wd, prev_wa, prev_wd;

   assign slot_idx  = IW'(slot_ff);
   assign in_range  = int'(slot_ff) < SLOTS;
   assign rel_ok    = in_range && busy_ff[slot_idx];
   assign full      = (used_ff == FULL_COUNT);

   assign next_q    = next_rd_vld_ff ? next_rd_ff : ring_next(next_rd_addr_ff);
   assign prev_s_q  = prev_s_vld_ff ? prev_s_rd_ff : ring_prev(prev_s_addr_ff);
   assign prev_o_q  = prev_o_vld_ff ? prev_o_rd_ff : ring_prev(prev_o_addr_ff);

   assign cur       = first_ff ? oldest_ff : next_q;
   assign walk_done = (in_range && (cur == slot_idx)) || (rank_ff == FULL_COUNT);
   assign walk_step = cmd.walk && !walk_done;

   assign h_c  = (oldest_ff == slot_idx) ? next_q : oldest_ff;
   assign hp_c = (h_c == next_q) ? prev_s_q : prev_o_q;

   assign rel_commit   = cmd.finish && (func_ff == aosa_pkg::FUNC_RELEASE) && rel_ok;
   assign alloc_commit = cmd.finish && (func_ff == aosa_pkg::FUNC_ALLOC) && !full;

   assign sts.func      = func_ff;
   assign sts.rel_ok    = rel_ok;
   assign sts.walk_done = walk_done;

   assign next_re = cmd.lookup || walk_step;
   assign prev_re = cmd.lookup;

   always_comb begin
      if (cmd.walk) begin
         next_ra = cur;
      end else if (func_ff == aosa_pkg::FUNC_ALLOC) begin
         next_ra = free_ff;
      end else begin
         next_ra = slot_idx;
      end
   end

   always_comb begin
      next_we = 1'b0;
      prev_we = 1'b0;
      next_wa = slot_idx;
      next_wd = h_ff;
      prev_wa = h_ff;
      prev_wd = slot_idx;
      if (cmd.link_a) begin
         next_we = 1'b1;
         prev_we = 1'b1;
         next_wa = prev_s_q;
         next_wd = next_q;
         prev_wa = next_q;
         prev_wd = prev_s_q;
      end else if (cmd.link_b) begin
         next_we = 1'b1;
         prev_we = 1'b1;
         next_wa = hp_ff;
         next_wd = slot_idx;
         prev_wa = slot_idx;
         prev_wd = hp_ff;
      end else if (rel_commit) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (next_re) begin
         next_rd_ff      <= next_mem[next_ra];
         next_rd_addr_ff <= next_ra;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (prev_re) begin
         prev_s_rd_ff   <= prev_mem[slot_idx];
         prev_s_addr_ff <= slot_idx;
         prev_o_rd_ff   <= prev_mem[oldest_ff];
         prev_o_addr_ff <= oldest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff    <= '0;
         prev_vld_ff    <= '0;
         next_rd_vld_ff <= 1'b0;
         prev_s_vld_ff  <= 1'b0;
         prev_o_vld_ff  <= 1'b0;
      end else begin
         if (next_we) begin
            next_vld_ff[next_wa] <= 1'b1;
         end
         if (prev_we) begin
            prev_vld_ff[prev_wa] <= 1'b1;
         end
         if (next_re) begin
            next_rd_vld_ff <= next_vld_ff[next_ra];
         end
         if (prev_re) begin
            prev_s_vld_ff <= prev_vld_ff[slot_idx];
            prev_o_vld_ff <= prev_vld_ff[oldest_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_data.func;
         slot_ff <= req_data.slot;
      end
      if (cmd.link_a) begin
         h_ff  <= h_c;
         hp_ff <= hp_c;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      oldest_in = oldest_ff;
      free_in   = free_ff;
      used_in   = used_ff;
      busy_in   = busy_ff;
      if (alloc_commit) begin
         busy_in[free_ff] = 1'b1;
         used_in          = CW'(used_ff + 1'b1);
         free_in          = next_q;
      end else if (rel_commit) begin
         busy_in[slot_idx] = 1'b0;
         used_in           = CW'(used_ff - 1'b1);
         oldest_in         = h_ff;
         if (full) begin
            free_in = slot_idx;
         end
      end
   end

   always_comb begin
      rsp_in          = '0;
      rsp_in.status   = aosa_pkg::STATUS_OK;
      rsp_in.in_use   = 6'(used_in);
      case (func_ff)
         aosa_pkg::FUNC_ALLOC: begin
            if (full) begin
               rsp_in.status = aosa_pkg::STATUS_FULL;
            end else begin
               rsp_in.slot_out = 5'(free_ff);
            end
         end
         aosa_pkg::FUNC_RELEASE: begin
            if (!rel_ok) begin
               rsp_in.status = aosa_pkg::STATUS_NOT_BUSY;
            end
         end
         aosa_pkg::FUNC_SUCC: begin
            if (in_range) begin
               rsp_in.slot_out = 5'(next_q);
            end
         end
         aosa_pkg::FUNC_RANK: begin
            rsp_in.age_rank = 6'(rank_ff);
         end
         default: begin
            rsp_in.status = aosa_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         free_ff   <= '0;
         used_ff   <= '0;
         busy_ff   <= '0;
         first_ff  <= 1'b0;
         rank_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         free_ff   <= free_in;
         used_ff   <= used_in;
         busy_ff   <= busy_in;
         strobe_ff <= cmd.finish;
         if (cmd.lookup) begin
            first_ff <= 1'b1;
            rank_ff  <= '0;
         end else if (walk_step) begin
            first_ff <= 1'b0;
            rank_ff  <= CW'(rank_ff + 1'b1);
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ sv/age_ordered_slot_allocator.sv @@
// Channel   Ports                 Transfer taken when
// request   start, busy, req_data start high and busy low at a rising edge
// response  rsp_strobe, rsp_data  rsp_strobe high, for exactly one cycle
//
// Allocate, successor and a refused release pass through the lookup and finish
// states. A release also passes through link_a and link_b, and an age-rank query
// also passes through walk, where it follows k links (k at most SLOTS).
// The walk is set by the next-link table, which gives one registered read a cycle.
// Reset is synchronous and restores the ring through per-entry
// valid bits. The response cannot be stalled; busy is low again in its cycle.
module age_ordered_slot_allocator #(
   parameter int SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  aosa_pkg::req_type req_data,
   output logic              rsp_strobe,
   output aosa_pkg::rsp_type rsp_data
);

   aosa_pkg::cmd_type cmd;
   aosa_pkg::sts_type sts;

   aosa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   aosa_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
